// File: rtl/clr_pkg.sv
`default_nettype none

package clr_pkg;

   localparam int CSR_ADDR_BITS = 2;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_CLIP_MIN_X = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_CLIP_MAX_X = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_CLIP_MIN_Y = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_CLIP_MAX_Y = 2'd3;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   typedef struct packed {
      logic kept;
      logic last_pixel;
      logic idle;
   } rsp_flags_type;

endpackage

`default_nettype wire

// File: rtl/clr_front.sv
`default_nettype none

module clr_front #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic                         req_op,
   input  wire logic [4*COORD_BITS-1:0]      req_coords,
   input  wire logic                         item_take,
   output logic                              item_valid,
   output logic                              item_op,
   output logic [4*COORD_BITS-1:0]           item_coords
);

   logic                    valid_ff;
   logic                    valid_in;
   logic                    op_ff;
   logic [4*COORD_BITS-1:0] coords_ff;

   assign req_tready = !valid_ff || item_take;

   always_comb begin
      valid_in = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff     <= req_op;
         coords_ff <= req_coords;
      end
   end

   assign item_valid  = valid_ff;
   assign item_op     = op_ff;
   assign item_coords = coords_ff;

endmodule

`default_nettype wire

// File: rtl/clr_walk.sv
`default_nettype none

module clr_walk #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wr_en,
   input  wire logic [clr_pkg::CSR_ADDR_BITS-1:0]    csr_addr,
   input  wire logic [COORD_BITS-1:0]                csr_wdata,
   input  wire logic                                 item_valid,
   input  wire logic                                 item_op,
   input  wire logic [4*COORD_BITS-1:0]              item_coords,
   output logic                                      item_take,
   input  wire logic                                 rsp_tready,
   output logic                                      rsp_valid,
   output logic [COORD_BITS-1:0]                     rsp_pix_x,
   output logic [COORD_BITS-1:0]                     rsp_pix_y,
   output clr_pkg::rsp_flags_type                    rsp_flags
);

   import clr_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int EB = COORD_BITS + 3;

   // clip box
   logic signed [C-1:0] clip_min_x_ff, clip_max_x_ff, clip_min_y_ff, clip_max_y_ff;

   // line state
   logic                active_ff, steep_ff, backward_ff, minor_up_ff;
   logic signed [C-1:0] major_pos_ff, minor_pos_ff, major_stop_ff;
   logic signed [C+1:0] err_acc_ff;
   logic signed [C:0]   major_delta_ff, minor_delta_ff;

   logic                active_in, steep_in, backward_in, minor_up_in;
   logic signed [C-1:0] major_pos_in, minor_pos_in, major_stop_in;
   logic signed [C+1:0] err_acc_in;
   logic signed [C:0]   major_delta_in, minor_delta_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [C-1:0]        pix_x_ff, pix_x_in, pix_y_ff, pix_y_in;
   rsp_flags_type       flags_ff, flags_in;

   logic                out_free, do_load, do_step;

   // load datapath
   logic signed [C-1:0] sx, sy, ex, ey;
   logic signed [C:0]   dx, dy, adx, ady;
   logic                ld_steep;
   logic signed [C-1:0] smaj, smin, emaj, emin;

   // step datapath
   logic signed [C-1:0] px, py;
   logic                clip_off, kept, last;
   logic signed [EB-1:0] err_e, majd_e, mind_e, sum_e, dbl_e, neg_majd_e, err_next_e;
   logic                minor_move;
   logic signed [C-1:0] mstep;

   assign sx = item_coords[C-1:0];
   assign sy = item_coords[2*C-1:C];
   assign ex = item_coords[3*C-1:2*C];
   assign ey = item_coords[4*C-1:3*C];

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign do_load   = item_valid && (item_op == OP_LOAD);
   assign do_step   = item_valid && (item_op == OP_STEP) && out_free;
   assign item_take = do_load || do_step;

   always_comb begin
      dx       = {ex[C-1], ex} - {sx[C-1], sx};
      dy       = {ey[C-1], ey} - {sy[C-1], sy};
      adx      = dx[C] ? -dx : dx;
      ady      = dy[C] ? -dy : dy;
      ld_steep = ady > adx;
      smaj     = ld_steep ? sy : sx;
      smin     = ld_steep ? sx : sy;
      emaj     = ld_steep ? ey : ex;
      emin     = ld_steep ? ex : ey;
   end

   always_comb begin
      px       = steep_ff ? minor_pos_ff : major_pos_ff;
      py       = steep_ff ? major_pos_ff : minor_pos_ff;
      clip_off = (clip_min_x_ff == clip_max_x_ff) || (clip_min_y_ff == clip_max_y_ff);
      kept     = clip_off || (px >= clip_min_x_ff && px < clip_max_x_ff &&
                              py >= clip_min_y_ff && py < clip_max_y_ff);
      last     = major_pos_ff == major_stop_ff;
      mstep    = minor_up_ff ? C'(1) : {C{1'b1}};

      err_e      = {err_acc_ff[C+1], err_acc_ff};
      majd_e     = {2'b00, major_delta_ff};
      mind_e     = {2'b00, minor_delta_ff};
      neg_majd_e = -majd_e;
      sum_e      = backward_ff ? (err_e - mind_e) : (err_e + mind_e);
      dbl_e      = sum_e <<< 1;
      minor_move = backward_ff ? (dbl_e < neg_majd_e) : (dbl_e >= majd_e);
      err_next_e = sum_e;
      if (minor_move) begin
         err_next_e = backward_ff ? (sum_e + majd_e) : (sum_e - majd_e);
      end
   end

   always_comb begin
      active_in      = active_ff;
      steep_in       = steep_ff;
      backward_in    = backward_ff;
      minor_up_in    = minor_up_ff;
      major_pos_in   = major_pos_ff;
      minor_pos_in   = minor_pos_ff;
      major_stop_in  = major_stop_ff;
      err_acc_in     = err_acc_ff;
      major_delta_in = major_delta_ff;
      minor_delta_in = minor_delta_ff;
      if (do_load) begin
         active_in      = 1'b1;
         steep_in       = ld_steep;
         backward_in    = smaj > emaj;
         minor_up_in    = emin > smin;
         major_pos_in   = smaj;
         minor_pos_in   = smin;
         major_stop_in  = emaj;
         err_acc_in     = '0;
         major_delta_in = ld_steep ? ady : adx;
         minor_delta_in = ld_steep ? adx : ady;
      end else if (do_step && active_ff) begin
         if (last) begin
            active_in = 1'b0;
         end else begin
            major_pos_in = backward_ff ? (major_pos_ff - C'(1)) : (major_pos_ff + C'(1));
            err_acc_in   = err_next_e[C+1:0];
            if (minor_move) begin
               minor_pos_in = minor_pos_ff + mstep;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      pix_x_in     = pix_x_ff;
      pix_y_in     = pix_y_ff;
      flags_in     = flags_ff;
      if (do_step) begin
         rsp_valid_in = 1'b1;
         if (active_ff) begin
            pix_x_in            = px;
            pix_y_in            = py;
            flags_in.kept       = kept;
            flags_in.last_pixel = last;
            flags_in.idle       = 1'b0;
         end else begin
            pix_x_in            = '0;
            pix_y_in            = '0;
            flags_in.kept       = 1'b0;
            flags_in.last_pixel = 1'b0;
            flags_in.idle       = 1'b1;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_min_x_ff <= '0;
         clip_max_x_ff <= '0;
         clip_min_y_ff <= '0;
         clip_max_y_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_CLIP_MIN_X: clip_min_x_ff <= csr_wdata;
            CSR_CLIP_MAX_X: clip_max_x_ff <= csr_wdata;
            CSR_CLIP_MIN_Y: clip_min_y_ff <= csr_wdata;
            CSR_CLIP_MAX_Y: clip_max_y_ff <= csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         steep_ff       <= 1'b0;
         backward_ff    <= 1'b0;
         minor_up_ff    <= 1'b0;
         major_pos_ff   <= '0;
         minor_pos_ff   <= '0;
         major_stop_ff  <= '0;
         err_acc_ff     <= '0;
         major_delta_ff <= '0;
         minor_delta_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         active_ff      <= active_in;
         steep_ff       <= steep_in;
         backward_ff    <= backward_in;
         minor_up_ff    <= minor_up_in;
         major_pos_ff   <= major_pos_in;
         minor_pos_ff   <= minor_pos_in;
         major_stop_ff  <= major_stop_in;
         err_acc_ff     <= err_acc_in;
         major_delta_ff <= major_delta_in;
         minor_delta_ff <= minor_delta_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_x_ff <= pix_x_in;
      pix_y_ff <= pix_y_in;
      flags_ff <= flags_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pix_x = pix_x_ff;
   assign rsp_pix_y = pix_y_ff;
   assign rsp_flags = flags_ff;

endmodule

`default_nettype wire

// File: rtl/clipped_line_rasterizer.sv
// a step request is held in the front register on acceptance, its response then in
//   the output register once free; throughput: one request per cycle unless the
//   output stalls; a pixel step is one add, compare and increment
// a load request gives no response and leaves the output register untouched
// synchronous reset clears the clip box, the active line and both stages' valid bits
`default_nettype none

module clipped_line_rasterizer #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          csr_wr_en,
   input  wire logic [clr_pkg::CSR_ADDR_BITS-1:0]             csr_addr,
   input  wire logic [COORD_BITS-1:0]                         csr_wdata,
   input  wire logic                                          req_tvalid,
   output logic                                               req_tready,
   // start_x, start_y, end_x, end_y
   input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]             req_tdata,
   // op
   input  wire logic                                          req_tuser,
   output logic                                               rsp_tvalid,
   input  wire logic                                          rsp_tready,
   // pix_x, pix_y, kept
   output logic [((2*COORD_BITS+1+7)/8)*8-1:0]                rsp_tdata,
   output logic                                               rsp_tlast,
   // idle
   output logic                                               rsp_tuser
);

   import clr_pkg::*;

   logic                    item_valid, item_op, item_take;
   logic [4*COORD_BITS-1:0] item_coords;
   logic [COORD_BITS-1:0]   pix_x, pix_y;
   rsp_flags_type           flags;

   clr_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .req_coords (req_tdata[4*COORD_BITS-1:0]),
      .item_take  (item_take),
      .item_valid (item_valid),
      .item_op    (item_op),
      .item_coords(item_coords)
   );

   clr_walk #(
      .COORD_BITS(COORD_BITS)
   ) u_walk (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item_op    (item_op),
      .item_coords(item_coords),
      .item_take  (item_take),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_pix_x  (pix_x),
      .rsp_pix_y  (pix_y),
      .rsp_flags  (flags)
   );

   always_comb begin
      rsp_tdata                               = '0;
      rsp_tdata[COORD_BITS-1:0]               = pix_x;
      rsp_tdata[2*COORD_BITS-1:COORD_BITS]    = pix_y;
      rsp_tdata[2*COORD_BITS]                 = flags.kept;
   end

   assign rsp_tlast = flags.last_pixel;
   assign rsp_tuser = flags.idle;

endmodule

`default_nettype wire
